FILE: src/esma_pkg.sv
`timescale 1ns / 1ps

package esma_pkg;

    localparam int POS_IN_W  = 12;
    localparam int POS_MAX_W = 16;
    localparam int PERIOD_W  = 20;
    localparam int SPEED_W   = 16;
    localparam int SCALE_W   = 32;

    // Degrees per revolution times tenths times microseconds per second.
    localparam logic [SCALE_W-1:0] SPEED_SCALE = 32'd3600000000;

    localparam logic [SPEED_W-1:0] SPEED_POS_MAX = 16'h7FFF;
    localparam logic [SPEED_W-1:0] SPEED_NEG_MIN = 16'h8000;

    typedef struct packed {
        logic capture;
        logic multiply;
        logic div_speed;
        logic update;
        logic div_mean;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic div_busy;
    } t_dp_status;

endpackage

FILE: src/esma_div.sv
`timescale 1ns / 1ps

module esma_div #(
    parameter int DVD_W = 44,
    parameter int DVS_W = 20,
    parameter int CNT_W = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    input  logic [CNT_W-1:0] i_steps,
    output logic             o_busy,
    output logic [DVD_W-1:0] o_quotient
);

    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;

    logic [DVS_W:0]   trial;
    logic             fits;
    logic [DVS_W:0]   diff;

    always_comb begin
        trial = {r_rem, r_quo[DVD_W-1]};
        fits  = (trial >= {1'b0, r_dvs});
        diff  = trial - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_steps;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVD_W-2:0], fits};
            r_rem <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

FILE: src/esma_ctrl.sv
`timescale 1ns / 1ps

module esma_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output esma_pkg::t_dp_cmd   o_cmd,
    input  esma_pkg::t_dp_status i_status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV_SPD,
        S_WAIT_SPD,
        S_UPDATE,
        S_DIV_AVG,
        S_WAIT_AVG,
        S_HOLD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.multiply = 1'b1;
                n_state        = S_DIV_SPD;
            end
            S_DIV_SPD: begin
                o_cmd.div_speed = 1'b1;
                n_state         = S_WAIT_SPD;
            end
            S_WAIT_SPD: begin
                if (!i_status.div_busy) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_DIV_AVG;
            end
            S_DIV_AVG: begin
                o_cmd.div_mean = 1'b1;
                n_state        = S_WAIT_AVG;
            end
            S_WAIT_AVG: begin
                if (!i_status.div_busy) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: src/esma_datapath.sv
`timescale 1ns / 1ps

module esma_datapath #(
    parameter int AVG_LENGTH = 5,
    parameter int POS_BITS   = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  esma_pkg::t_dp_cmd                   i_cmd,
    output esma_pkg::t_dp_status                o_status,
    input  logic [esma_pkg::POS_IN_W-1:0]       i_position,
    input  logic [esma_pkg::PERIOD_W-1:0]       i_period_us,
    output logic signed [esma_pkg::SPEED_W-1:0] o_avg_speed
);

    localparam int MAG_W  = POS_BITS + esma_pkg::SCALE_W;
    localparam int SUM_W  = esma_pkg::SPEED_W + $clog2(AVG_LENGTH);
    localparam int SLOT_W = (AVG_LENGTH > 1) ? $clog2(AVG_LENGTH) : 1;
    localparam int CNT_W  = $clog2(MAG_W + 1);
    localparam int SPD_W  = esma_pkg::SPEED_W;

    // The mean is the magnitude of the sum times a rounded-up reciprocal of the
    // history length, shifted right; the shift is wide enough to make it exact.
    localparam int MEAN_SH = SUM_W + $clog2(AVG_LENGTH);
    localparam int RCP_W   = MEAN_SH + 1;
    localparam int MPROD_W = SUM_W + RCP_W;
    localparam logic [RCP_W-1:0] MEAN_RCP =
        RCP_W'(((longint'(1) << MEAN_SH) + longint'(AVG_LENGTH) - longint'(1))
               / longint'(AVG_LENGTH));

    logic [POS_BITS-1:0]               r_last_pos;
    logic [POS_BITS-1:0]               r_delta_mag;
    logic                              r_delta_neg;
    logic [esma_pkg::PERIOD_W-1:0]     r_period;
    logic [MAG_W-1:0]                  r_product;
    logic signed [SPD_W-1:0]           r_hist [AVG_LENGTH];
    logic [SLOT_W-1:0]                 r_slot;
    logic signed [SUM_W-1:0]           r_sum;
    logic                              r_mean_neg;
    logic [MPROD_W-1:0]                r_mean_prod;
    logic signed [SPD_W-1:0]           r_avg;

    logic [esma_pkg::POS_MAX_W-1:0]    pos_wide;
    logic [POS_BITS-1:0]               pos;
    logic signed [POS_BITS:0]          diff;
    logic signed [POS_BITS:0]          delta;
    logic [POS_BITS:0]                 delta_neg_val;
    logic [MAG_W-1:0]                  n_product;

    logic                              div_start;
    logic [MAG_W-1:0]                  div_dividend;
    logic [esma_pkg::PERIOD_W-1:0]     div_divisor;
    logic [CNT_W-1:0]                  div_steps;
    logic                              div_busy;
    logic [MAG_W-1:0]                  div_quo;

    logic [MAG_W-POS_BITS-1:0]         spd_mag;
    logic signed [SPD_W-1:0]           speed;
    logic signed [SUM_W-1:0]           n_sum;
    logic [SUM_W-1:0]                  abs_sum;
    logic [MPROD_W-1:0]                n_mean_prod;
    logic [SPD_W-1:0]                  mean_mag;

    localparam logic signed [POS_BITS:0] HALF = (POS_BITS + 1)'(1 << (POS_BITS - 1));
    localparam logic signed [POS_BITS:0] REV  = (POS_BITS + 1)'(1 << POS_BITS);

    always_comb begin
        pos_wide      = esma_pkg::POS_MAX_W'(i_position);
        pos           = pos_wide[POS_BITS-1:0];
        diff          = $signed({1'b0, pos}) - $signed({1'b0, r_last_pos});
        if (diff > HALF) begin
            delta = diff - REV;
        end else if (diff < -HALF) begin
            delta = diff + REV;
        end else begin
            delta = diff;
        end
        delta_neg_val = -delta;
        n_product     = {{esma_pkg::SCALE_W{1'b0}}, r_delta_mag}
                      * {{POS_BITS{1'b0}}, esma_pkg::SPEED_SCALE};
    end

    always_comb begin
        spd_mag = div_quo[MAG_W-1:POS_BITS];
        if (!r_delta_neg) begin
            speed = (spd_mag > (MAG_W - POS_BITS)'(32767))
                  ? esma_pkg::SPEED_POS_MAX : spd_mag[SPD_W-1:0];
        end else begin
            speed = (spd_mag > (MAG_W - POS_BITS)'(32768))
                  ? esma_pkg::SPEED_NEG_MIN : -spd_mag[SPD_W-1:0];
        end
        n_sum       = r_sum - SUM_W'(r_hist[r_slot]) + SUM_W'(speed);
        abs_sum     = r_sum[SUM_W-1] ? -r_sum : r_sum;
        n_mean_prod = MPROD_W'(abs_sum) * MPROD_W'(MEAN_RCP);
        mean_mag    = r_mean_prod[MEAN_SH +: SPD_W];
    end

    always_comb begin
        div_start    = i_cmd.div_speed;
        div_dividend = r_product;
        div_divisor  = r_period;
        div_steps    = CNT_W'(MAG_W);
    end

    esma_div #(
        .DVD_W (MAG_W),
        .DVS_W (esma_pkg::PERIOD_W),
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .i_steps    (div_steps),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_pos <= '0;
            r_slot     <= '0;
            r_sum      <= '0;
            for (int k = 0; k < AVG_LENGTH; k++) begin
                r_hist[k] <= '0;
            end
        end else begin
            if (i_cmd.capture) begin
                r_last_pos <= pos;
            end
            if (i_cmd.update) begin
                r_hist[r_slot] <= speed;
                r_sum          <= n_sum;
                if (r_slot == SLOT_W'(AVG_LENGTH - 1)) begin
                    r_slot <= '0;
                end else begin
                    r_slot <= r_slot + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_delta_neg <= delta[POS_BITS];
            r_delta_mag <= delta[POS_BITS] ? delta_neg_val[POS_BITS-1:0]
                                           : delta[POS_BITS-1:0];
            r_period    <= (i_period_us == '0) ? esma_pkg::PERIOD_W'(1) : i_period_us;
        end
        if (i_cmd.multiply) begin
            r_product <= n_product;
        end
        if (i_cmd.div_mean) begin
            r_mean_neg  <= r_sum[SUM_W-1];
            r_mean_prod <= n_mean_prod;
        end
        if (i_cmd.load_out) begin
            r_avg <= r_mean_neg ? -mean_mag : mean_mag;
        end
    end

    assign o_status.div_busy = div_busy;
    assign o_avg_speed       = r_avg;

endmodule

FILE: src/encoder_speed_moving_average_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                   Payload
// input     in         i_in_valid / o_in_stall     i_position, i_period_us
// output    out        o_out_valid / i_out_stall   o_avg_speed
//
// A word passes capture, multiplication, speed division, history update and the mean
// product to the output register; the next word is accepted the cycle after it loads.
// The speed division is done by the serial restoring divider, which produces one quotient
// bit per cycle; the mean over the history is a reciprocal multiplication.
// Reset is synchronous and clears the history, the running sum and the last position.
// A new word is accepted while the previous result waits under i_out_stall.

module encoder_speed_moving_average_core #(
    parameter int AVG_LENGTH = 5,
    parameter int POS_BITS   = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [esma_pkg::POS_IN_W-1:0]       i_position,
    input  logic [esma_pkg::PERIOD_W-1:0]       i_period_us,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [esma_pkg::SPEED_W-1:0] o_avg_speed
);

    esma_pkg::t_dp_cmd    cmd;
    esma_pkg::t_dp_status status;

    esma_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    esma_datapath #(
        .AVG_LENGTH (AVG_LENGTH),
        .POS_BITS   (POS_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_position  (i_position),
        .i_period_us (i_period_us),
        .o_avg_speed (o_avg_speed)
    );

endmodule

FILE: src/esma_checker.sv
`timescale 1ns / 1ps

module esma_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_stall,
    input logic        i_out_valid,
    input logic        i_out_stall,
    input logic [15:0] i_avg_speed
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_avg_speed))
        else $error("stalled output word changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_stall |=> i_in_stall)
        else $error("input not stalled while a word is in progress");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_result_follows_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_stall))
        else $error("result appeared without a word in progress");

endmodule

bind encoder_speed_moving_average_core esma_checker u_esma_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_avg_speed (o_avg_speed)
);

FILE: bench/encoder_speed_moving_average_core_tb.sv
`timescale 1ns / 1ps

module encoder_speed_moving_average_core_tb;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_WORDS = 1536;
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 800;
    localparam int DRAIN_CYCLES = 150;
    localparam int IDLE_PERCENT = 21;

    class avg_speed_scoreboard;
        localparam int HIST_DEPTH = 5;
        localparam int REV_COUNTS = 4096;
        localparam int HALF_REV   = 2048;

        logic [esma_pkg::POS_IN_W-1:0] last_pos;
        logic signed [esma_pkg::SPEED_W-1:0] speed_hist [HIST_DEPTH];
        int unsigned hist_slot;
        int speed_sum;
        logic signed [esma_pkg::SPEED_W-1:0] expected_avg [$];
        int errors;

        function new();
            last_pos  = '0;
            hist_slot = 0;
            speed_sum = 0;
            errors    = 0;
            foreach (speed_hist[k]) speed_hist[k] = '0;
        endfunction

        function void note_sample(input logic [esma_pkg::POS_IN_W-1:0] pos,
                                  input logic [esma_pkg::PERIOD_W-1:0] period);
            longint delta;
            longint num;
            longint den;
            longint q;
            logic signed [esma_pkg::SPEED_W-1:0] speed;
            delta = longint'(pos) - longint'(last_pos);
            if (delta > HALF_REV) begin
                delta -= REV_COUNTS;
            end else if (delta < -HALF_REV) begin
                delta += REV_COUNTS;
            end
            last_pos = pos;
            num = delta * longint'(esma_pkg::SPEED_SCALE);
            den = (period == '0) ? longint'(REV_COUNTS) : longint'(period) * REV_COUNTS;
            q = num / den;
            if (q > 32767) begin
                speed = esma_pkg::SPEED_POS_MAX;
            end else if (q < -32768) begin
                speed = esma_pkg::SPEED_NEG_MIN;
            end else begin
                speed = q[esma_pkg::SPEED_W-1:0];
            end
            speed_sum = speed_sum - int'(speed_hist[hist_slot]) + int'(speed);
            speed_hist[hist_slot] = speed;
            hist_slot = (hist_slot + 1) % HIST_DEPTH;
            expected_avg.push_back(16'(speed_sum / HIST_DEPTH));
        endfunction

        function void check_avg_speed(input logic signed [esma_pkg::SPEED_W-1:0] actual);
            logic signed [esma_pkg::SPEED_W-1:0] want;
            if (expected_avg.size() == 0) begin
                if (errors < 50) begin
                    $display("%0t: avg_speed with no word pending, expected none, actual %0d",
                             $time, actual);
                end
                errors++;
            end else begin
                want = expected_avg.pop_front();
                if (actual !== want) begin
                    if (errors < 50) begin
                        $display("%0t: avg_speed mismatch, expected %0d, actual %0d",
                                 $time, want, actual);
                    end
                    errors++;
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    logic [esma_pkg::POS_IN_W-1:0] i_position;
    logic [esma_pkg::PERIOD_W-1:0] i_period_us;
    logic o_out_valid;
    logic i_out_stall;
    logic signed [esma_pkg::SPEED_W-1:0] o_avg_speed;

    avg_speed_scoreboard speed_board;
    logic [esma_pkg::POS_IN_W-1:0] prev_pos = '0;
    bit quiet_phase = 1'b0;
    int results_seen = 0;
    int cycle_count = 0;

    encoder_speed_moving_average_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_position  (i_position),
        .i_period_us (i_period_us),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_avg_speed (o_avg_speed)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                speed_board.note_sample(i_position, i_period_us);
            end
            if (o_out_valid && !i_out_stall) begin
                speed_board.check_avg_speed(o_avg_speed);
                results_seen++;
            end
        end
    end

    // The receiver holds off once for a long stretch so that the block backs up.
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                i_out_stall <= !quiet_phase && ($urandom_range(99) < IDLE_PERCENT);
            end
        end
    end

    task automatic send_word(input logic [esma_pkg::POS_IN_W-1:0] pos,
                             input logic [esma_pkg::PERIOD_W-1:0] period);
        while (!quiet_phase && $urandom_range(99) < IDLE_PERCENT) begin
            i_in_valid  <= 1'b0;
            i_position  <= 12'($urandom);
            i_period_us <= 20'($urandom);
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_position  <= pos;
        i_period_us <= period;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        prev_pos = pos;
    endtask

    task automatic send_random_word();
        int unsigned mode;
        logic [esma_pkg::POS_IN_W-1:0] pos;
        logic [esma_pkg::PERIOD_W-1:0] period;
        mode = $urandom_range(99);
        if (mode < 45) begin
            pos    = prev_pos + 12'($urandom_range(80)) - 12'd40;
            period = 20'($urandom_range(5000, 100));
        end else if (mode < 60) begin
            pos    = prev_pos + 12'd2048 + 12'($urandom_range(4)) - 12'd2;
            period = 20'($urandom);
        end else if (mode < 72) begin
            pos    = prev_pos + 12'($urandom_range(6)) - 12'd3;
            period = 20'($urandom_range(3));
        end else if (mode < 85) begin
            pos    = 12'($urandom);
            period = 20'($urandom) >> $urandom_range(19);
        end else begin
            pos    = 12'($urandom);
            period = 20'($urandom);
        end
        send_word(pos, period);
    endtask

    initial begin
        speed_board = new();
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_position  = '0;
        i_period_us = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_word(12'd0,    20'd0);
        send_word(12'd2048, 20'd1);
        send_word(12'd0,    20'd1);
        send_word(12'd2049, 20'd1000);
        send_word(12'd0,    20'd1000);
        send_word(12'd4095, 20'hFFFFF);
        send_word(12'd0,    20'hFFFFF);
        send_word(12'd1,    20'd1);
        send_word(12'd5,    20'd200);
        send_word(12'd1,    20'd200);
        send_word(12'hAAA,  20'hAAAAA);
        send_word(12'h555,  20'h55555);
        send_word(12'd2603, 20'd0);
        send_word(12'd555,  20'd0);
        send_word(12'd600,  20'd2500);
        send_word(12'd590,  20'd2500);
        send_word(12'd580,  20'd7);
        send_word(12'd580,  20'd1);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            quiet_phase = (n >= 600 && n < 800);
            send_random_word();
        end
        quiet_phase = 1'b0;
        i_in_valid <= 1'b0;

        while (speed_board.expected_avg.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (speed_board.errors == 0 && speed_board.expected_avg.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
